/* rtl/twap_pkg.sv */
// Shared types and constants for the time-weighted ARMA predictor.
// Used by twap_ctrl, twap_dp and the top level; no dependencies.
package twap_pkg;

    localparam int COEF_REGS = 3;
    localparam int TAP_W     = 4;   // holds tap counts up to 14 plus one
    localparam int HORNER_N  = 10;

    localparam logic [2:0] REG_DECAY  = 3'd0;
    localparam logic [2:0] REG_AR_1   = 3'd1;
    localparam logic [2:0] REG_AR_2   = 3'd2;
    localparam logic [2:0] REG_AR_3   = 3'd3;
    localparam logic [2:0] REG_MA_1   = 3'd4;
    localparam logic [2:0] REG_MA_2   = 3'd5;
    localparam logic [2:0] REG_MA_3   = 3'd6;

    localparam logic [28:0] EXP_M1_Q30 = 29'd395007542;
    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_X,
        OP_DIV_STEP,
        OP_H_MUL,
        OP_H_RCP,
        OP_H_UPD,
        OP_K_MUL,
        OP_W_RND,
        OP_CW,
        OP_T_LO,
        OP_T_HI,
        OP_AR_ACC,
        OP_MA_MUL,
        OP_MA_ACC,
        OP_PRED,
        OP_COMMIT
    } op_t;

    typedef struct packed {
        logic             take;
        op_t              op;
        logic [TAP_W-1:0] tap;
        logic [3:0]       n;
    } cmd_t;

    typedef struct packed {
        logic             decay_zero;
        logic             k_big;
        logic [3:0]       k;
        logic [TAP_W-1:0] count;
        logic             out_free;
    } status_t;

    // floor(2^32 / n) for the Horner divisors
    function automatic logic [32:0] recip(input logic [3:0] n);
        logic [32:0] r;
        case (n)
            4'd1:    r = 33'h1_0000_0000;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/twap_ctrl.sv */
// Sequencer for the predictor: walks AR taps (weight, product, accumulate),
// MA taps, then saturation and history commit. Depends on twap_pkg.
module twap_ctrl #(
    parameter int AR_TAPS = 3,
    parameter int MA_TAPS = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  twap_pkg::status_t status,
    output twap_pkg::cmd_t    cmd
);
    import twap_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_AR_SEL, S_DIV, S_EXP_CHK, S_H_MUL, S_H_RCP, S_H_UPD, S_K_MUL,
        S_WRND, S_CW, S_T_LO, S_T_HI, S_AR_ACC, S_MA_SEL, S_MA_ACC, S_COMMIT
    } state_t;

    state_t           state_reg;
    logic [TAP_W-1:0] tap_reg;
    logic [3:0]       n_reg;
    logic [3:0]       kcnt_reg;
    logic [4:0]       dcnt_reg;

    logic ar_live, ma_live;

    assign ar_live = (tap_reg <= TAP_W'(AR_TAPS)) && (tap_reg <= status.count)
                  && (tap_reg <= TAP_W'(COEF_REGS));
    assign ma_live = (tap_reg <= TAP_W'(MA_TAPS)) && (tap_reg <= status.count)
                  && (tap_reg <= TAP_W'(COEF_REGS));

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd.take = s_tready && s_tvalid;
        cmd.tap  = tap_reg;
        cmd.n    = n_reg;
        case (state_reg)
            S_AR_SEL: cmd.op = ar_live ? OP_X : OP_NONE;
            S_DIV:    cmd.op = OP_DIV_STEP;
            S_H_MUL:  cmd.op = OP_H_MUL;
            S_H_RCP:  cmd.op = OP_H_RCP;
            S_H_UPD:  cmd.op = OP_H_UPD;
            S_K_MUL:  cmd.op = OP_K_MUL;
            S_WRND:   cmd.op = OP_W_RND;
            S_CW:     cmd.op = OP_CW;
            S_T_LO:   cmd.op = OP_T_LO;
            S_T_HI:   cmd.op = OP_T_HI;
            S_AR_ACC: cmd.op = OP_AR_ACC;
            S_MA_SEL: cmd.op = ma_live ? OP_MA_MUL : OP_PRED;
            S_MA_ACC: cmd.op = OP_MA_ACC;
            S_COMMIT: cmd.op = status.out_free ? OP_COMMIT : OP_NONE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
            n_reg     <= '0;
            kcnt_reg  <= '0;
            dcnt_reg  <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        tap_reg   <= TAP_W'(1);
                        state_reg <= S_AR_SEL;
                    end
                end
                S_AR_SEL: begin
                    if (!ar_live) begin
                        tap_reg   <= TAP_W'(1);
                        state_reg <= S_MA_SEL;
                    end else if (status.decay_zero) begin
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_EXP_CHK;
                    end
                end
                S_DIV: begin
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd16) begin
                        state_reg <= S_WRND;
                    end
                end
                S_EXP_CHK: begin
                    kcnt_reg  <= status.k;
                    n_reg     <= 4'(HORNER_N);
                    state_reg <= status.k_big ? S_WRND : S_H_MUL;
                end
                S_H_MUL: state_reg <= S_H_RCP;
                S_H_RCP: state_reg <= S_H_UPD;
                S_H_UPD: begin
                    n_reg <= n_reg - 4'd1;
                    if (n_reg == 4'd1) begin
                        state_reg <= (kcnt_reg == 4'd0) ? S_WRND : S_K_MUL;
                    end else begin
                        state_reg <= S_H_MUL;
                    end
                end
                S_K_MUL: begin
                    kcnt_reg <= kcnt_reg - 4'd1;
                    if (kcnt_reg == 4'd1) begin
                        state_reg <= S_WRND;
                    end
                end
                S_WRND: state_reg <= S_CW;
                S_CW:   state_reg <= S_T_LO;
                S_T_LO: state_reg <= S_T_HI;
                S_T_HI: state_reg <= S_AR_ACC;
                S_AR_ACC: begin
                    tap_reg   <= tap_reg + TAP_W'(1);
                    state_reg <= S_AR_SEL;
                end
                S_MA_SEL: begin
                    if (ma_live) begin
                        state_reg <= S_MA_ACC;
                    end else begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_MA_ACC: begin
                    tap_reg   <= tap_reg + TAP_W'(1);
                    state_reg <= S_MA_SEL;
                end
                S_COMMIT: begin
                    if (status.out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/twap_dp.sv */
// Datapath: config registers, history, weight unit (divider and exp steps),
// multipliers, accumulator, saturation and output register. Uses twap_pkg.
module twap_dp #(
    parameter int AR_TAPS = 3,
    parameter int MA_TAPS = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_addr,
    input  logic [15:0]       cfg_wdata,
    input  logic [47:0]       s_tdata,
    input  logic              s_tuser,
    input  logic              m_tready,
    input  twap_pkg::cmd_t    cmd,
    output twap_pkg::status_t status,
    output logic              m_tvalid,
    output logic [63:0]       m_tdata,
    output logic              m_tuser
);
    import twap_pkg::*;

    localparam int HIST  = (AR_TAPS > MA_TAPS) ? AR_TAPS : MA_TAPS;
    localparam int IDX_W = (HIST > 1) ? $clog2(HIST) : 1;
    localparam int ACC_W = 40;

    logic [15:0]        decay_reg;
    logic signed [15:0] ar_coef_reg [COEF_REGS];
    logic signed [15:0] ma_coef_reg [COEF_REGS];

    logic signed [31:0] vals_reg [HIST];
    logic [15:0]        gaps_reg [HIST];
    logic signed [31:0] res_reg  [HIST];
    logic [TAP_W-1:0]   count_reg;

    logic signed [31:0]      sample_reg;
    logic [15:0]             gap_in_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [31:0]             x_reg;
    logic [30:0]             p_reg;
    logic [46:0]             m_reg;
    logic [30:0]             q_reg;
    logic [63:0]             prod_reg;
    logic [17:0]             rem_reg;
    logic [16:0]             quo_reg;
    logic [16:0]             den_reg;
    logic [16:0]             w_reg;
    logic signed [33:0]      cw_reg;
    logic signed [65:0]      t_reg;
    logic signed [31:0]      pred_reg;
    logic                    clip_reg;
    logic                    out_valid_reg;
    logic [63:0]             out_data_reg;
    logic                    out_flag_reg;

    // tap selection
    logic [TAP_W-1:0]   tap_m1;
    logic [IDX_W-1:0]   idx;
    logic [1:0]         cidx;
    logic signed [31:0] sel_val, sel_res;
    logic [15:0]        sel_gap;
    logic signed [15:0] ar_c, ma_c;

    assign tap_m1  = cmd.tap - TAP_W'(1);
    assign idx     = tap_m1[IDX_W-1:0];
    assign cidx    = tap_m1[1:0];
    assign sel_val = vals_reg[idx];
    assign sel_gap = gaps_reg[idx];
    assign sel_res = res_reg[idx];
    assign ar_c    = (cidx == 2'd3) ? 16'sd0 : ar_coef_reg[cidx];
    assign ma_c    = (cidx == 2'd3) ? 16'sd0 : ma_coef_reg[cidx];

    // arithmetic
    logic [16:0]             d_val, num_val;
    logic [17:0]             rem_s;
    logic                    rem_ge;
    logic [30:0]             qe, qn, rdiff, qfix;
    logic [34:0]             qn_full;
    logic [60:0]             pk;
    logic [30:0]             p_rnd;
    logic signed [65:0]      lo_prod, hi_prod;
    logic signed [65:0]      ar_sum;
    logic signed [65:0]      ma_sum;
    logic signed [ACC_W-1:0] acc_next;
    logic                    acc_ovf;
    logic signed [31:0]      pred_next;
    logic signed [32:0]      diff;
    logic signed [31:0]      resid_next;
    logic                    diff_ovf;

    assign d_val   = {1'b0, sel_gap} + 17'd1;
    assign num_val = 17'h1_0000 + {1'b0, d_val[16:1]};
    assign rem_s   = {rem_reg[16:0], quo_reg[16]};
    assign rem_ge  = rem_s >= {1'b0, den_reg};
    assign qe      = prod_reg[62:32];
    assign qn_full = qe * cmd.n;
    assign qn      = qn_full[30:0];
    assign rdiff   = q_reg - qn;
    assign qfix    = (rdiff >= {27'd0, cmd.n}) ? qe + 31'd1 : qe;
    assign pk      = p_reg * EXP_M1_Q30 + 61'h2000_0000;
    assign p_rnd   = p_reg + 31'd8192;
    assign lo_prod = 66'(cw_reg * $signed({1'b0, sel_val[15:0]}));
    assign hi_prod = 66'(cw_reg * $signed(sel_val[31:16])) <<< 16;
    assign ar_sum  = (t_reg + 66'sd536870912) >>> 30;
    assign ma_sum  = (t_reg + 66'sd8192) >>> 14;

    always_comb begin
        acc_next = acc_reg;
        case (cmd.op)
            OP_AR_ACC: acc_next = acc_reg + ar_sum[ACC_W-1:0];
            OP_MA_ACC: acc_next = acc_reg + ma_sum[ACC_W-1:0];
            default:   acc_next = acc_reg;
        endcase
    end

    assign acc_ovf   = !((&acc_reg[ACC_W-1:31]) || !(|acc_reg[ACC_W-1:31]));
    assign pred_next = acc_ovf ? (acc_reg[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                               : acc_reg[31:0];
    assign diff       = {sample_reg[31], sample_reg} - {pred_reg[31], pred_reg};
    assign diff_ovf   = diff[32] != diff[31];
    assign resid_next = diff_ovf ? (diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                 : diff[31:0];

    always_comb begin
        status.decay_zero = (decay_reg == 16'd0);
        status.k_big      = |x_reg[31:20];
        status.k          = x_reg[19:16];
        status.count      = count_reg;
        status.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < COEF_REGS; i++) begin
                ar_coef_reg[i] <= '0;
                ma_coef_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_addr)
                    REG_DECAY: decay_reg      <= cfg_wdata;
                    REG_AR_1:  ar_coef_reg[0] <= cfg_wdata;
                    REG_AR_2:  ar_coef_reg[1] <= cfg_wdata;
                    REG_AR_3:  ar_coef_reg[2] <= cfg_wdata;
                    REG_MA_1:  ma_coef_reg[0] <= cfg_wdata;
                    REG_MA_2:  ma_coef_reg[1] <= cfg_wdata;
                    REG_MA_3:  ma_coef_reg[2] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.take && s_tuser) begin
                count_reg <= '0;
            end else if (cmd.op == OP_COMMIT && count_reg < TAP_W'(HIST)) begin
                count_reg <= count_reg + TAP_W'(1);
            end
            if (cmd.op == OP_COMMIT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            sample_reg <= s_tdata[31:0];
            gap_in_reg <= s_tdata[47:32];
            acc_reg    <= '0;
        end else begin
            acc_reg <= acc_next;
        end
        case (cmd.op)
            OP_X: begin
                x_reg   <= sel_gap * decay_reg;
                p_reg   <= Q30_ONE;
                den_reg <= d_val;
                quo_reg <= num_val;
                rem_reg <= '0;
            end
            OP_DIV_STEP: begin
                rem_reg <= rem_ge ? rem_s - {1'b0, den_reg} : rem_s;
                quo_reg <= {quo_reg[15:0], rem_ge};
            end
            OP_H_MUL: m_reg <= x_reg[15:0] * p_reg;
            OP_H_RCP: begin
                q_reg    <= m_reg[46:16];
                prod_reg <= m_reg[46:16] * recip(cmd.n);
            end
            OP_H_UPD: p_reg <= Q30_ONE - qfix;
            OP_K_MUL: p_reg <= pk[60:30];
            OP_W_RND: begin
                if (decay_reg == 16'd0) begin
                    w_reg <= quo_reg;
                end else if (status.k_big) begin
                    w_reg <= '0;
                end else begin
                    w_reg <= p_rnd[30:14];
                end
            end
            OP_CW:     cw_reg <= 34'(ar_c * $signed({1'b0, w_reg}));
            OP_T_LO:   t_reg  <= lo_prod;
            OP_T_HI:   t_reg  <= t_reg + hi_prod;
            OP_MA_MUL: t_reg  <= 66'(ma_c * sel_res);
            OP_PRED: begin
                pred_reg <= pred_next;
                clip_reg <= acc_ovf;
            end
            OP_COMMIT: begin
                for (int i = HIST - 1; i > 0; i--) begin
                    vals_reg[i] <= vals_reg[i-1];
                    gaps_reg[i] <= gaps_reg[i-1];
                    res_reg[i]  <= res_reg[i-1];
                end
                vals_reg[0]  <= sample_reg;
                gaps_reg[0]  <= gap_in_reg;
                res_reg[0]   <= resid_next;
                out_data_reg <= {resid_next, pred_reg};
                out_flag_reg <= clip_reg || diff_ovf;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/time_weighted_arma_predictor_top.sv */
// Usage notes
// One-step ARMA predictor with gap-dependent AR weights, Q16.16 data.
// Input stream (s_*): one beat per sample; s_tdata = sample_value[31:0],
//   time_gap[47:32]; s_tuser = series_start (clears history before use).
// Output stream (m_*): one beat per sample; m_tdata = prediction[31:0],
//   residual[63:32]; m_tuser = saturated_flag.
// Config channel (cfg_*): index 0 decay_rate, 1..3 AR lags, 4..6 MA lags,
//   16-bit data; cfg_ready is always high, write only while no sample is in work.
// The time from input beat to result grows with the weight work of each live
//   AR tap and with each live MA tap; the next beat is taken only after the
//   result is loaded. Reciprocal weighting (decay_rate zero) runs a 17-step
//   restoring divider per tap; exponential weighting runs 10 Horner steps,
//   then k exp(-1) multiplies (k < 16), and skips both when the exponent is
//   16 or more. Live taps are those within the history count, the tap
//   parameter and lag three. One sample is in work at a time.
// Reset clears config, the history count and the output valid flag.
// The output register frees the sequencer; a stalled receiver holds the next
//   result in the commit step, and no new sample is taken until it lands.
module time_weighted_arma_predictor_top #(
    parameter int AR_TAPS = 3,
    parameter int MA_TAPS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sample_value[31:0], time_gap[47:32]
    input  logic        s_tuser,   // series_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // prediction[31:0], residual[63:32]
    output logic        m_tuser    // saturated_flag
);
    import twap_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    twap_ctrl #(.AR_TAPS(AR_TAPS), .MA_TAPS(MA_TAPS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    twap_dp #(.AR_TAPS(AR_TAPS), .MA_TAPS(MA_TAPS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* rtl/twap_checker.sv */
// Port-level checks for the predictor top, attached with bind.
// Depends only on the top-level port list.
module twap_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // a held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // one sample in work at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while busy");

    // no result in the cycle after an input beat
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind time_weighted_arma_predictor_top twap_checker u_twap_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
